[hdl/polar_transform_encoder_assert.svh]
// Assertion macros for the polar transform encoder checker.
// Expects clk and rst_n in the scope of each use.
`ifndef POLAR_TRANSFORM_ENCODER_ASSERT_SVH
`define POLAR_TRANSFORM_ENCODER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define PTE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("polar transform encoder check failed");

// Next-cycle implication, off during reset.
`define PTE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("polar transform encoder check failed");

// Condition that must hold in the cycle after reset is seen.
`define PTE_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("polar transform encoder reset check failed");

`endif

[hdl/pte_pkg.sv]
// Package for the polar transform encoder: sizes, sequencer states, the
// in-word butterfly function and the size clamp. No dependencies.
package pte_pkg;

  localparam int MAX_SIZE_LOG   = 10;
  localparam int MIN_SIZE_LOG   = 5;
  localparam int WORD_LOG       = 5;
  localparam int WORD_BITS      = 32;
  localparam int SIZE_W         = 4;
  localparam int STORE_DEPTH    = 2 ** (MAX_SIZE_LOG - WORD_LOG);
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int WLOG_W         = $clog2(MAX_SIZE_LOG - WORD_LOG + 1);
  localparam logic [SIZE_W-1:0] SIZE_LOG_RESET = SIZE_W'(10);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [ADDR_W:0]      count_t;
  typedef logic [WLOG_W-1:0]    wlog_t;
  typedef logic [SIZE_W-1:0]    size_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_BF_HI,
    S_BF_LO,
    S_BF_WR,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_WAIT
  } state_t;

  // Stages of size 32 down to 2 inside one word: low half ^= high half.
  function automatic word_t word_transform(input word_t v);
    word_t x;
    x = v;
    x = x ^ ((x >> 16) & 32'h0000_FFFF);
    x = x ^ ((x >> 8)  & 32'h00FF_00FF);
    x = x ^ ((x >> 4)  & 32'h0F0F_0F0F);
    x = x ^ ((x >> 2)  & 32'h3333_3333);
    x = x ^ ((x >> 1)  & 32'h5555_5555);
    return x;
  endfunction

  // Clamp the size register into the supported range.
  function automatic size_t active_log(input size_t s);
    size_t l;
    l = s;
    if (l < size_t'(MIN_SIZE_LOG)) l = size_t'(MIN_SIZE_LOG);
    if (l > size_t'(MAX_SIZE_LOG)) l = size_t'(MAX_SIZE_LOG);
    return l;
  endfunction

endpackage

[hdl/pte_if.sv]
// Valid/ready channel interfaces for the polar transform encoder.
// Depends on pte_pkg.
interface pte_in_if;
  logic            valid;
  logic            ready;
  pte_pkg::word_t  data_word;

  modport source (output valid, output data_word, input ready);
  modport sink   (input valid, input data_word, output ready);
endinterface

interface pte_out_if;
  logic            valid;
  logic            ready;
  pte_pkg::word_t  coded_word;
  logic            frame_end;

  modport source (output valid, output coded_word, output frame_end, input ready);
  modport sink   (input valid, input coded_word, input frame_end, output ready);
endinterface

[hdl/pte_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/polar_transform_encoder.sv]
// Polar transform encoder top level: frame load, word butterflies, output.
// Depends on pte_pkg, pte_in_if, pte_out_if and pte_ram.
//
//   channel | dir | payload               | handshake
//   in_ch   | in  | data_word[31:0]       | valid/ready
//   out_ch  | out | coded_word[31:0], end | valid/ready
//   cfg     | in  | cfg_wr_data[3:0]      | cfg_wr_en, no wait
//
// Load stores each accepted word. Per butterfly stage, each word pair of a
// W = N/32 word frame steps S_BF_HI, S_BF_LO, S_BF_WR; each output word
// steps S_OUT_RD, S_OUT_LD, S_OUT_WAIT, held there by any stall on out_ch.
// Input is not ready from the last word of a frame until its final item
// is taken. Reset is synchronous and clears control only; the store needs none.
module polar_transform_encoder (
  input  logic                  clk,
  input  logic                  rst_n,
  pte_in_if.sink                in_ch,
  pte_out_if.source             out_ch,
  input  logic                  cfg_wr_en,
  input  pte_pkg::size_t        cfg_wr_data
);

  pte_pkg::state_t state_r, state_nxt;
  pte_pkg::size_t  size_log_r;
  pte_pkg::count_t count_r, count_nxt;
  pte_pkg::wlog_t  wlog_r, wlog_nxt;
  pte_pkg::wlog_t  stage_r, stage_nxt;
  pte_pkg::addr_t  pair_r, pair_nxt;
  pte_pkg::addr_t  oidx_r, oidx_nxt;
  pte_pkg::word_t  hi_r, hi_nxt;
  pte_pkg::word_t  out_data_r, out_data_nxt;
  logic            out_end_r, out_end_nxt;
  logic            out_valid_r, out_valid_nxt;

  pte_pkg::wlog_t  wlog_now;
  pte_pkg::count_t words_now;
  pte_pkg::count_t count_inc;
  logic            frame_done;
  pte_pkg::addr_t  half_bit;
  pte_pkg::addr_t  half_mask;
  pte_pkg::addr_t  lo_addr;
  pte_pkg::addr_t  hi_addr;
  pte_pkg::count_t pairs_full;
  pte_pkg::addr_t  pair_last;
  pte_pkg::count_t words_full;
  pte_pkg::addr_t  oidx_last;
  logic            in_acc;
  logic            out_acc;
  logic            pass_last;

  logic            ram_we;
  pte_pkg::addr_t  ram_waddr;
  pte_pkg::word_t  ram_wdata;
  pte_pkg::addr_t  ram_raddr;
  pte_pkg::word_t  ram_rdata;

  pte_ram #(
    .WIDTH (pte_pkg::WORD_BITS),
    .DEPTH (pte_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready       = (state_r == pte_pkg::S_LOAD);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.coded_word = out_data_r;
  assign out_ch.frame_end  = out_end_r;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_valid_r && out_ch.ready;

  assign wlog_now   = pte_pkg::wlog_t'(pte_pkg::active_log(size_log_r)
                      - pte_pkg::size_t'(pte_pkg::WORD_LOG));
  assign words_now  = pte_pkg::count_t'(1) << wlog_now;
  assign count_inc  = count_r + pte_pkg::count_t'(1);
  assign frame_done = (count_inc >= words_now);

  assign half_bit  = pte_pkg::addr_t'(1) << stage_r;
  assign half_mask = half_bit - pte_pkg::addr_t'(1);
  assign lo_addr   = ((pair_r & ~half_mask) << 1) | (pair_r & half_mask);
  assign hi_addr   = lo_addr | half_bit;

  assign pairs_full = pte_pkg::count_t'(1) << (wlog_r - pte_pkg::wlog_t'(1));
  assign pair_last  = pte_pkg::addr_t'(pairs_full - pte_pkg::count_t'(1));
  assign words_full = pte_pkg::count_t'(1) << wlog_r;
  assign oidx_last  = pte_pkg::addr_t'(words_full - pte_pkg::count_t'(1));
  assign pass_last  = (pair_r == pair_last);

  // Store port steering.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_r[pte_pkg::ADDR_W-1:0];
    ram_wdata = in_ch.data_word;
    ram_raddr = hi_addr;
    case (state_r)
      pte_pkg::S_LOAD: begin
        ram_we = in_acc;
      end
      pte_pkg::S_BF_LO: begin
        ram_raddr = lo_addr;
      end
      pte_pkg::S_BF_WR: begin
        ram_we    = 1'b1;
        ram_waddr = lo_addr;
        ram_wdata = ram_rdata ^ hi_r;
      end
      pte_pkg::S_OUT_RD: begin
        ram_raddr = oidx_r;
      end
      default: begin
        ram_raddr = hi_addr;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pte_pkg::S_LOAD: begin
        if (in_acc && frame_done) begin
          state_nxt = (wlog_now == '0) ? pte_pkg::S_OUT_RD : pte_pkg::S_BF_HI;
        end
      end
      pte_pkg::S_BF_HI: state_nxt = pte_pkg::S_BF_LO;
      pte_pkg::S_BF_LO: state_nxt = pte_pkg::S_BF_WR;
      pte_pkg::S_BF_WR: begin
        if (pass_last && stage_r == '0) begin
          state_nxt = pte_pkg::S_OUT_RD;
        end else begin
          state_nxt = pte_pkg::S_BF_HI;
        end
      end
      pte_pkg::S_OUT_RD: state_nxt = pte_pkg::S_OUT_LD;
      pte_pkg::S_OUT_LD: state_nxt = pte_pkg::S_OUT_WAIT;
      pte_pkg::S_OUT_WAIT: begin
        if (out_acc) begin
          state_nxt = out_end_r ? pte_pkg::S_LOAD : pte_pkg::S_OUT_RD;
        end
      end
      default: state_nxt = pte_pkg::S_LOAD;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    count_nxt     = count_r;
    wlog_nxt      = wlog_r;
    stage_nxt     = stage_r;
    pair_nxt      = pair_r;
    oidx_nxt      = oidx_r;
    hi_nxt        = hi_r;
    out_data_nxt  = out_data_r;
    out_end_nxt   = out_end_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      pte_pkg::S_LOAD: begin
        if (in_acc) begin
          if (frame_done) begin
            count_nxt = '0;
            wlog_nxt  = wlog_now;
            stage_nxt = wlog_now - pte_pkg::wlog_t'(1);
            pair_nxt  = '0;
            oidx_nxt  = '0;
          end else begin
            count_nxt = count_inc;
          end
        end
      end
      pte_pkg::S_BF_LO: begin
        hi_nxt = ram_rdata;
      end
      pte_pkg::S_BF_WR: begin
        if (pass_last) begin
          pair_nxt  = '0;
          stage_nxt = stage_r - pte_pkg::wlog_t'(1);
        end else begin
          pair_nxt = pair_r + pte_pkg::addr_t'(1);
        end
      end
      pte_pkg::S_OUT_LD: begin
        out_data_nxt  = pte_pkg::word_transform(ram_rdata);
        out_end_nxt   = (oidx_r == oidx_last);
        out_valid_nxt = 1'b1;
      end
      pte_pkg::S_OUT_WAIT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          oidx_nxt      = oidx_r + pte_pkg::addr_t'(1);
        end
      end
      default: begin
        hi_nxt = hi_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pte_pkg::S_LOAD;
      size_log_r  <= pte_pkg::SIZE_LOG_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        size_log_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    wlog_r     <= wlog_nxt;
    stage_r    <= stage_nxt;
    pair_r     <= pair_nxt;
    oidx_r     <= oidx_nxt;
    hi_r       <= hi_nxt;
    out_data_r <= out_data_nxt;
    out_end_r  <= out_end_nxt;
  end

endmodule

[hdl/pte_checker.sv]
// Port-level checker for the polar transform encoder, bound to the top level.
// Depends on pte_pkg and polar_transform_encoder_assert.svh.
`include "polar_transform_encoder_assert.svh"

module pte_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input pte_pkg::word_t coded_word,
  input logic           frame_end
);

  `PTE_ASSERT_IMP(a_no_overlap, out_valid, !in_ready)
  `PTE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(coded_word) && $stable(frame_end))
  `PTE_ASSERT_NXT(a_load_quiet, in_valid && in_ready, !out_valid)
  `PTE_ASSERT_NXT(a_end_reopen, out_valid && out_ready && frame_end, in_ready && !out_valid)
  `PTE_ASSERT_RST(a_rst_idle, !out_valid && in_ready)

endmodule

bind polar_transform_encoder pte_checker u_pte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .coded_word (out_ch.coded_word),
  .frame_end  (out_ch.frame_end)
);
